FILE: hw/rtl/ptal_pkg.sv
// ----------------------------------------------------------------------------
// ptal_pkg
// Shared types and constants for the paper-tape absolute loader.
// ----------------------------------------------------------------------------
package ptal_pkg;

    // block layout constants
    localparam logic [15:0] HEADER_BYTES = 16'd6;
    localparam logic [15:0] LEAD_WORD    = 16'd1;
    localparam logic [15:0] END_ADDRESS  = 16'd1;

    // result kinds
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // one tape transaction
    typedef struct packed {
        logic       end_of_tape;
        logic [7:0] tape_byte;
    } tape_item_t;

    // one result transaction
    typedef struct packed {
        kind_t       result_kind;
        logic [15:0] word_data;
        logic [15:0] word_address;
    } result_t;

endpackage

FILE: hw/rtl/ptal_in_stage.sv
// ----------------------------------------------------------------------------
// ptal_in_stage
// Input register: captures one tape transaction and holds it for the core.
// ----------------------------------------------------------------------------
module ptal_in_stage
    import ptal_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  tape_item_t s_item,
    output logic       item_valid,
    input  logic       item_ready,
    output tape_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    tape_item_t item_reg;
    logic       load;

    // accept while empty or while the held item moves on
    assign s_ready = !valid_reg || item_ready;
    assign load    = s_valid && s_ready;

    // occupancy
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hw/rtl/ptal_core.sv
// ----------------------------------------------------------------------------
// ptal_core
// Tape parsing state machine and result register.
// ----------------------------------------------------------------------------
module ptal_core
    import ptal_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    output logic       item_ready,
    input  tape_item_t item,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res
);

    typedef enum logic [8:0] {
        PH_HUNT_LO = 9'b000000001,
        PH_HUNT_HI = 9'b000000010,
        PH_CNT_LO  = 9'b000000100,
        PH_CNT_HI  = 9'b000001000,
        PH_ADR_LO  = 9'b000010000,
        PH_ADR_HI  = 9'b000100000,
        PH_DATA_LO = 9'b001000000,
        PH_DATA_HI = 9'b010000000,
        PH_CHECK   = 9'b100000000
    } phase_t;

    phase_t      phase_reg,             phase_next;
    logic [7:0]  running_sum_reg,       running_sum_next;
    logic [7:0]  low_byte_hold_reg,     low_byte_hold_next;
    logic [15:0] block_byte_count_reg,  block_byte_count_next;
    logic [15:0] load_word_address_reg, load_word_address_next;
    logic [14:0] words_left_reg,        words_left_next;
    logic        finished_reg,          finished_next;
    logic        out_valid_reg,         out_valid_next;
    result_t     out_reg;

    logic        consume;
    logic        has_res;
    result_t     new_res;
    logic [7:0]  b;
    logic [7:0]  sum_add;
    logic [15:0] w;
    logic [14:0] wl_init;

    // take an item when the result register is free or draining
    assign item_ready = !out_valid_reg || res_ready;
    assign consume    = item_valid && item_ready;

    assign b       = item.tape_byte;
    assign sum_add = running_sum_reg + b;
    assign w       = {b, low_byte_hold_reg};
    assign wl_init = block_byte_count_reg[15:1] - 15'd3;

    // next state and result
    always_comb begin
        phase_next             = phase_reg;
        running_sum_next       = running_sum_reg;
        low_byte_hold_next     = low_byte_hold_reg;
        block_byte_count_next  = block_byte_count_reg;
        load_word_address_next = load_word_address_reg;
        words_left_next        = words_left_reg;
        finished_next          = finished_reg;
        has_res                = 1'b0;
        new_res                = '{result_kind: KIND_WRITE, word_data: 16'd0,
                                   word_address: 16'd0};
        if (consume && !finished_reg) begin
            if (item.end_of_tape) begin
                // tape ran out: clean only between blocks
                finished_next = 1'b1;
                has_res       = 1'b1;
                new_res.result_kind = (phase_reg inside {PH_HUNT_LO, PH_HUNT_HI})
                                      ? KIND_DONE : KIND_ERROR;
            end else begin
                if (phase_reg != PH_HUNT_LO) begin
                    running_sum_next = sum_add;
                end
                case (phase_reg)
                    PH_HUNT_HI: begin
                        phase_next = (w == LEAD_WORD) ? PH_CNT_LO : PH_HUNT_LO;
                    end
                    PH_CNT_LO: begin
                        low_byte_hold_next = b;
                        phase_next         = PH_CNT_HI;
                    end
                    PH_CNT_HI: begin
                        block_byte_count_next = w;
                        phase_next            = PH_ADR_LO;
                    end
                    PH_ADR_LO: begin
                        low_byte_hold_next = b;
                        phase_next         = PH_ADR_HI;
                    end
                    PH_ADR_HI: begin
                        if (w == END_ADDRESS) begin
                            finished_next       = 1'b1;
                            has_res             = 1'b1;
                            new_res.result_kind = KIND_DONE;
                        end else if (block_byte_count_reg == 16'd0) begin
                            phase_next = PH_HUNT_LO;
                        end else if (block_byte_count_reg < HEADER_BYTES ||
                                     block_byte_count_reg[0]) begin
                            finished_next       = 1'b1;
                            has_res             = 1'b1;
                            new_res.result_kind = KIND_ERROR;
                        end else begin
                            load_word_address_next = {1'b0, w[15:1]};
                            words_left_next        = wl_init;
                            phase_next = (wl_init != 15'd0) ? PH_DATA_LO : PH_CHECK;
                        end
                    end
                    PH_DATA_LO: begin
                        low_byte_hold_next = b;
                        phase_next         = PH_DATA_HI;
                    end
                    PH_DATA_HI: begin
                        load_word_address_next = load_word_address_reg + 16'd1;
                        words_left_next        = words_left_reg - 15'd1;
                        phase_next = (words_left_reg != 15'd1) ? PH_DATA_LO : PH_CHECK;
                        has_res              = 1'b1;
                        new_res.word_address = load_word_address_reg;
                        new_res.word_data    = w;
                    end
                    PH_CHECK: begin
                        if (sum_add != 8'd0) begin
                            finished_next       = 1'b1;
                            has_res             = 1'b1;
                            new_res.result_kind = KIND_ERROR;
                        end else begin
                            phase_next = PH_HUNT_LO;
                        end
                    end
                    default: begin
                        // hunting for the lead byte
                        phase_next = PH_HUNT_LO;
                        if (b == LEAD_WORD[7:0]) begin
                            running_sum_next   = b;
                            low_byte_hold_next = b;
                            phase_next         = PH_HUNT_HI;
                        end
                    end
                endcase
            end
        end
    end

    // result register occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (consume) begin
            out_valid_next = has_res;
        end else if (res_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg             <= PH_HUNT_LO;
            running_sum_reg       <= 8'd0;
            low_byte_hold_reg     <= 8'd0;
            block_byte_count_reg  <= 16'd0;
            load_word_address_reg <= 16'd0;
            words_left_reg        <= 15'd0;
            finished_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
        end else begin
            phase_reg             <= phase_next;
            running_sum_reg       <= running_sum_next;
            low_byte_hold_reg     <= low_byte_hold_next;
            block_byte_count_reg  <= block_byte_count_next;
            load_word_address_reg <= load_word_address_next;
            words_left_reg        <= words_left_next;
            finished_reg          <= finished_next;
            out_valid_reg         <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (consume && has_res) begin
            out_reg <= new_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

FILE: hw/rtl/paper_tape_absolute_loader.sv
// ----------------------------------------------------------------------------
// paper_tape_absolute_loader
// Absolute loader for a paper-tape image fed as a byte stream.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one tape byte per transaction in s_tdata[7:0];
//   s_tlast high marks end of tape and the byte is then ignored.
//   m_ channel carries at most one result per input byte: m_tuser is the
//   kind (memory word write, load finished, format error), m_tdata holds
//   the word address in [15:0] and the data word in [31:16].
//   throughput is one byte per cycle: the input register, one pass of the
//   parse state machine and the result register keep a new byte flowing
//   in every cycle as long as results are taken.
//   a byte is held in the input register, then its result in the result register.
//   when m_tready is low the result register holds its transaction, the
//   held input waits and s_tready falls once the input register is full.
//   after a finished or error result, further bytes are accepted and give
//   no results until reset.
//   reset (aresetn low, synchronous) empties both registers and returns the
//   loader to hunting for the lead byte with a cleared checksum.
// ----------------------------------------------------------------------------
module paper_tape_absolute_loader
    import ptal_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] tape_byte
    input  logic        s_tlast,   // end_of_tape
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] word_address, [31:16] word_data
    output logic [1:0]  m_tuser    // [1:0] result_kind
);

    tape_item_t s_item;
    tape_item_t item;
    logic       item_valid;
    logic       item_ready;
    result_t    res;

    assign s_item.tape_byte   = s_tdata;
    assign s_item.end_of_tape = s_tlast;

    // input register
    ptal_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // parser and result register
    ptal_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {res.word_data, res.word_address};
    assign m_tuser = res.result_kind;

endmodule

FILE: dv/paper_tape_absolute_loader_tb.sv
// ----------------------------------------------------------------------------
// paper_tape_absolute_loader_tb
// Self-checking bench for the paper-tape absolute loader. A queue of tape
// bytes (directed blocks, then random well-formed blocks with noise between
// them, then one randomly chosen way of ending the tape) is streamed in with
// random gaps. A predictor updated on every accepted byte produces the
// expected memory writes and finish/error results. Each result is compared
// field by field as it leaves the loader.
// ----------------------------------------------------------------------------
module paper_tape_absolute_loader_tb
    import ptal_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // parse states of the predictor
    typedef enum logic [3:0] {
        ST_SEEK_LEAD,
        ST_SEEK_ZERO,
        ST_COUNT_LO,
        ST_COUNT_HI,
        ST_ADDR_LO,
        ST_ADDR_HI,
        ST_WORD_LO,
        ST_WORD_HI,
        ST_SUM
    } parse_st_t;

    // one pending tape transaction
    typedef struct {
        logic [7:0] tape_byte;
        logic       end_of_tape;
        bit         drain_first;
    } tape_tx_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    tape_tx_t    tape_q[$];
    result_t     loader_results[$];
    logic [15:0] block_words[$];
    result_t     want;

    // predictor state
    parse_st_t   tp_state = ST_SEEK_LEAD;
    logic [7:0]  tp_sum   = 8'h00;
    logic [7:0]  tp_hold  = 8'h00;
    logic [15:0] tp_count = 16'h0000;
    logic [15:0] tp_waddr = 16'h0000;
    logic [14:0] tp_left  = 15'h0000;
    bit          tp_done  = 1'b0;

    bit          drain_next = 1'b0;
    bit          s_took     = 1'b0;
    bit          steady     = 1'b0;
    int          src_gap    = 0;
    int          sink_gap   = 0;
    int          fail_count = 0;
    int          bytes_in   = 0;
    int          words_seen = 0;
    string       tape_ending;

    paper_tape_absolute_loader u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always #10 aclk = ~aclk;

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void push_result(kind_t k, logic [15:0] addr, logic [15:0] data);
        result_t r;
        r.result_kind  = k;
        r.word_address = addr;
        r.word_data    = data;
        loader_results.push_back(r);
    endfunction

    // load is over, nothing more comes out until reset
    function automatic void stop_load(kind_t k);
        tp_done = 1'b1;
        push_result(k, 16'h0000, 16'h0000);
    endfunction

    // advance the loader model by one accepted tape byte
    function automatic void loader_step(logic [7:0] b, logic eot);
        logic [15:0] w;
        if (tp_done)
            return;
        if (eot) begin
            if (tp_state inside {ST_SEEK_LEAD, ST_SEEK_ZERO})
                stop_load(KIND_DONE);
            else
                stop_load(KIND_ERROR);
            return;
        end
        if (tp_state != ST_SEEK_LEAD)
            tp_sum = tp_sum + b;
        w = {b, tp_hold};
        case (tp_state)
            ST_SEEK_LEAD: begin
                if (b == LEAD_WORD[7:0]) begin
                    tp_sum   = b;
                    tp_hold  = b;
                    tp_state = ST_SEEK_ZERO;
                end
            end
            ST_SEEK_ZERO: tp_state = (w == LEAD_WORD) ? ST_COUNT_LO : ST_SEEK_LEAD;
            ST_COUNT_LO: begin
                tp_hold  = b;
                tp_state = ST_COUNT_HI;
            end
            ST_COUNT_HI: begin
                tp_count = w;
                tp_state = ST_ADDR_LO;
            end
            ST_ADDR_LO: begin
                tp_hold  = b;
                tp_state = ST_ADDR_HI;
            end
            ST_ADDR_HI: begin
                if (w == END_ADDRESS) begin
                    stop_load(KIND_DONE);
                end else if (tp_count == 16'h0000) begin
                    tp_state = ST_SEEK_LEAD;
                end else if (tp_count < HEADER_BYTES || tp_count[0]) begin
                    stop_load(KIND_ERROR);
                end else begin
                    tp_waddr = w >> 1;
                    tp_left  = 15'((tp_count - HEADER_BYTES) >> 1);
                    tp_state = (tp_left != 15'h0000) ? ST_WORD_LO : ST_SUM;
                end
            end
            ST_WORD_LO: begin
                tp_hold  = b;
                tp_state = ST_WORD_HI;
            end
            ST_WORD_HI: begin
                push_result(KIND_WRITE, tp_waddr, w);
                tp_waddr = tp_waddr + 16'h0001;
                tp_left  = tp_left - 15'h0001;
                tp_state = (tp_left != 15'h0000) ? ST_WORD_LO : ST_SUM;
            end
            default: begin
                if (tp_sum != 8'h00)
                    stop_load(KIND_ERROR);
                else
                    tp_state = ST_SEEK_LEAD;
            end
        endcase
    endfunction

    function automatic void push_byte(logic [7:0] b, logic eot);
        tape_tx_t t;
        t.tape_byte   = b;
        t.end_of_tape = eot;
        t.drain_first = drain_next;
        drain_next    = 1'b0;
        tape_q.push_back(t);
    endfunction

    // block from block_words; keep < 0 sends it whole, else only its first bytes
    function automatic void add_block(logic [15:0] count, logic [15:0] addr, bit bad_sum,
                                      int keep);
        logic [7:0] b[$];
        logic [7:0] sum;
        b.push_back(8'h01);
        b.push_back(8'h00);
        b.push_back(count[7:0]);
        b.push_back(count[15:8]);
        b.push_back(addr[7:0]);
        b.push_back(addr[15:8]);
        foreach (block_words[i]) begin
            b.push_back(block_words[i][7:0]);
            b.push_back(block_words[i][15:8]);
        end
        if (count != 16'h0000) begin
            sum = 8'h00;
            foreach (b[i])
                sum = sum + b[i];
            sum = 8'h00 - sum;
            if (bad_sum)
                sum = sum + 8'($urandom_range(1, 255));
            b.push_back(sum);
        end
        foreach (b[i])
            if (keep < 0 || i < keep)
                push_byte(b[i], 1'b0);
        block_words.delete();
    endfunction

    function automatic void add_random_words(int n);
        for (int i = 0; i < n; i++)
            block_words.push_back(16'($urandom_range(0, 65535)));
    endfunction

    // random data block, address never the end address
    function automatic void add_data_block();
        int          n;
        logic [15:0] addr;
        n    = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40);
        addr = 16'($urandom_range(0, 65535));
        if (addr == END_ADDRESS)
            addr = 16'h0000;
        add_random_words(n);
        add_block(16'(HEADER_BYTES + 2 * n), addr, 1'b0, -1);
    endfunction

    // junk between blocks: stray bytes and lead bytes with a nonzero follower
    function automatic void add_noise();
        int n;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                push_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(2, 255)),
                          1'b0);
            end else begin
                push_byte(8'h01, 1'b0);
                push_byte(8'($urandom_range(1, 255)), 1'b0);
            end
        end
    endfunction

    // one way of ending the tape, chosen at random
    function automatic void add_tape_end();
        int          n;
        int          total;
        logic [15:0] addr;
        addr = 16'($urandom_range(0, 65535));
        if (addr == END_ADDRESS)
            addr = 16'h0002;
        case ($urandom_range(0, 6))
            0: begin
                tape_ending = "tape end while hunting";
                add_noise();
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            1: begin
                tape_ending = "tape end after a lone lead byte";
                push_byte(8'h01, 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            2: begin
                tape_ending = "tape end inside a block";
                n     = $urandom_range(0, 6);
                total = 7 + 2 * n;
                add_random_words(n);
                add_block(16'(HEADER_BYTES + 2 * n), addr, 1'b0, $urandom_range(2, total - 1));
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            3: begin
                tape_ending = "end address";
                add_block(16'($urandom_range(0, 65535)), END_ADDRESS, 1'b0, -1);
            end
            4: begin
                tape_ending = "short count";
                add_block(16'($urandom_range(1, 5)), addr, 1'b0, -1);
            end
            5: begin
                tape_ending = "odd count";
                add_random_words($urandom_range(0, 3));
                add_block(16'($urandom_range(3, 32767) * 2 + 1), addr, 1'b0, -1);
            end
            default: begin
                tape_ending = "bad checksum";
                n = $urandom_range(0, 6);
                add_random_words(n);
                add_block(16'(HEADER_BYTES + 2 * n), addr, 1'b1, -1);
            end
        endcase
    endfunction

    // monitor: track accepts, predict, and check results
    always @(posedge aclk) begin
        if (aresetn) begin
            if ($urandom_range(0, 199) == 0)
                steady = !steady;
            s_took = s_tvalid && s_tready;
            if (s_took) begin
                bytes_in++;
                loader_step(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (loader_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, actual kind %0d tdata %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = loader_results.pop_front();
                    if (m_tuser !== want.result_kind) begin
                        fail_count++;
                        $display("%0t: result_kind mismatch: expected %0d, actual %0d",
                                 $time, want.result_kind, m_tuser);
                    end
                    if (m_tdata[15:0] !== want.word_address) begin
                        fail_count++;
                        $display("%0t: word_address mismatch: expected %h, actual %h",
                                 $time, want.word_address, m_tdata[15:0]);
                    end
                    if (m_tdata[31:16] !== want.word_data) begin
                        fail_count++;
                        $display("%0t: word_data mismatch: expected %h, actual %h",
                                 $time, want.word_data, m_tdata[31:16]);
                    end
                    if (want.result_kind == KIND_WRITE)
                        words_seen++;
                end
            end
        end
    end

    // driver: next tape transaction once the current one is taken
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_took)) begin
            if (src_gap > 0) begin
                s_tvalid <= 1'b0;
                src_gap--;
            end else if (tape_q.size() != 0 &&
                         !(tape_q[0].drain_first && loader_results.size() != 0)) begin
                s_tdata  <= tape_q[0].tape_byte;
                s_tlast  <= tape_q[0].end_of_tape;
                s_tvalid <= 1'b1;
                void'(tape_q.pop_front());
                src_gap = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (sink_gap > 0) begin
                m_tready <= 1'b0;
                sink_gap--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    sink_gap = pick_gap();
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int wait_cycles;

        // false lead, empty block, block of six, data extremes at top address
        push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b0);
        add_block(16'h0000, 16'hFFFE, 1'b0, -1);
        add_block(16'h0006, 16'h0000, 1'b0, -1);
        block_words.push_back(16'h0000);
        block_words.push_back(16'hFFFF);
        add_block(16'h000A, 16'hFFFF, 1'b0, -1);

        // random blocks with noise in between, full drains midway
        while (tape_q.size() < 1200) begin
            add_noise();
            if (tape_q.size() > 600 && tape_q.size() < 700)
                drain_next = 1'b1;
            if ($urandom_range(0, 19) == 0)
                add_block(16'h0000, 16'($urandom_range(2, 65535)), 1'b0, -1);
            else
                add_data_block();
        end

        // wait for every result before the tape end, then ignored bytes after it
        drain_next = 1'b1;
        add_tape_end();
        for (int i = 0; i < 24; i++)
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (tape_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        wait_cycles = 0;
        while (loader_results.size() != 0 && wait_cycles < 1000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (10) @(posedge aclk);

        if (loader_results.size() != 0) begin
            fail_count++;
            $display("%0t: %0d expected results never arrived, first kind %0d",
                     $time, loader_results.size(), loader_results[0].result_kind);
        end

        $display("run: %0d tape bytes accepted, %0d word writes checked", bytes_in, words_seen);
        $display("run: tape ended by %s", tape_ending);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
